[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define CTL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, masked during reset
`define CTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/ctl_pkg.sv]
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared constants, types and control structs for the tour length block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctl_pkg;

  localparam int CITY_COUNT = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(CITY_COUNT);
  localparam int TOTAL_W    = 40;
  localparam int FRAC_SHIFT = 16;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int SUMSQ_W    = PROD_W + 1;
  localparam int ROOT_W     = (SUMSQ_W + FRAC_SHIFT + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VISIT,
    ST_DIFF,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic mem_wr;
    logic mem_rd;
    logic start_tour;
    logic leg_ld;
    logic sel_close;
    logic mul_x;
    logic mul_y;
    logic root_init;
    logic root_step;
    logic acc;
    logic upd_prev;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic started;
  } sts_t;

endpackage

`default_nettype wire

[sv/ctl_ctrl.sv]
// ----------------------------------------------------------------------------
// ctl_ctrl
// Sequencer: request handshakes, leg scheduling and root step count.
// ----------------------------------------------------------------------------
`default_nettype none

module ctl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           in_action,
  input  wire logic           in_last_visit,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ctl_pkg::cmd_t       cmd,
  input  wire ctl_pkg::sts_t  sts
);

  ctl_pkg::state_t                state_r, state_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           last_r, last_nxt;
  logic                           close_r, close_nxt;
  logic [ctl_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                           accept;
  logic                           out_free;

  assign in_stall  = (state_r != ctl_pkg::ST_IDLE);
  assign accept    = in_valid && (state_r == ctl_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    close_r <= close_nxt;
    step_r  <= step_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    close_nxt     = close_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.sel_close = close_r;

    unique case (state_r)
      ctl_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action) begin
            cmd.mem_rd = 1'b1;
            last_nxt   = in_last_visit;
            state_nxt  = ctl_pkg::ST_VISIT;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      ctl_pkg::ST_VISIT: begin
        if (!sts.started) begin
          cmd.start_tour = 1'b1;
          close_nxt      = 1'b1;
          state_nxt      = last_r ? ctl_pkg::ST_DIFF : ctl_pkg::ST_IDLE;
        end else begin
          close_nxt = 1'b0;
          state_nxt = ctl_pkg::ST_DIFF;
        end
      end
      ctl_pkg::ST_DIFF: begin
        cmd.leg_ld = 1'b1;
        state_nxt  = ctl_pkg::ST_MUL_X;
      end
      ctl_pkg::ST_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_nxt = ctl_pkg::ST_MUL_Y;
      end
      ctl_pkg::ST_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_nxt = ctl_pkg::ST_ROOT_INIT;
      end
      ctl_pkg::ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = ctl_pkg::ST_ROOT;
      end
      ctl_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == ctl_pkg::STEP_W'(ctl_pkg::ROOT_W - 1)) begin
          state_nxt = ctl_pkg::ST_ACC;
        end
      end
      ctl_pkg::ST_ACC: begin
        cmd.acc      = 1'b1;
        cmd.upd_prev = !close_r;
        priority if (close_r) begin
          state_nxt = ctl_pkg::ST_EMIT;
        end else if (last_r) begin
          close_nxt = 1'b1;
          state_nxt = ctl_pkg::ST_DIFF;
        end else begin
          state_nxt = ctl_pkg::ST_IDLE;
        end
      end
      ctl_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ctl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ctl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/ctl_dp.sv]
// ----------------------------------------------------------------------------
// ctl_dp
// Datapath: city table, tour points, shared squarer, bit-serial root, total.
// ----------------------------------------------------------------------------
`default_nettype none

module ctl_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [9:0]                  in_city_index,
  input  wire logic signed [15:0]          in_coord_x,
  input  wire logic signed [15:0]          in_coord_y,
  input  wire ctl_pkg::cmd_t               cmd,
  output ctl_pkg::sts_t                    sts,
  output logic [ctl_pkg::TOTAL_W-1:0]      out_tour_length
);

  localparam int CB = ctl_pkg::COORD_BITS;

  ctl_pkg::point_t                  mem [ctl_pkg::CITY_COUNT];
  ctl_pkg::point_t                  cur_r, first_r, prev_r;
  ctl_pkg::point_t                  wr_pt;
  ctl_pkg::point_t                  pa, pb;
  logic [ctl_pkg::IDX_W-1:0]        addr;
  logic                             started_r;
  ctl_pkg::mag_t                    dx_r, dy_r, dx_nxt, dy_nxt, mul_op;
  logic signed [CB:0]               diff_x, diff_y, neg_x, neg_y;
  logic [ctl_pkg::PROD_W-1:0]       prod_r, sqx_r;
  logic [ctl_pkg::SUMSQ_W-1:0]      sumsq;
  logic [ctl_pkg::RAD_W-1:0]        rad_r;
  logic [ctl_pkg::REM_W-1:0]        rem_r, rem_nxt, rem_try, trial;
  logic [ctl_pkg::ROOT_W-1:0]       root_r, root_nxt;
  logic [ctl_pkg::TOTAL_W-1:0]      total_r, total_nxt, tour_length_r;
  logic [ctl_pkg::TOTAL_W:0]        total_sum;

  assign addr        = in_city_index[ctl_pkg::IDX_W-1:0];
  assign wr_pt.x     = ctl_pkg::coord_t'(in_coord_x);
  assign wr_pt.y     = ctl_pkg::coord_t'(in_coord_y);
  assign sts.started = started_r;
  assign out_tour_length = tour_length_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wr_pt;
    end
    if (cmd.mem_rd) begin
      cur_r <= mem[addr];
    end
  end

  // leg endpoints: new leg is cur-prev, closing leg is prev-first
  always_comb begin
    pa     = cmd.sel_close ? prev_r  : cur_r;
    pb     = cmd.sel_close ? first_r : prev_r;
    diff_x = {pa.x[CB-1], pa.x} - {pb.x[CB-1], pb.x};
    diff_y = {pa.y[CB-1], pa.y} - {pb.y[CB-1], pb.y};
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    dx_nxt = diff_x[CB] ? neg_x[CB-1:0] : diff_x[CB-1:0];
    dy_nxt = diff_y[CB] ? neg_y[CB-1:0] : diff_y[CB-1:0];
  end

  assign mul_op = cmd.mul_y ? dy_r : dx_r;
  assign sumsq  = ctl_pkg::SUMSQ_W'(sqx_r) + ctl_pkg::SUMSQ_W'(prod_r);

  // one root bit per step, two radicand bits consumed per step
  always_comb begin
    rem_try = {rem_r[ctl_pkg::REM_W-3:0], rad_r[ctl_pkg::RAD_W-1 -: 2]};
    trial   = ctl_pkg::REM_W'({root_r, 2'b01});
    if (rem_try >= trial) begin
      rem_nxt  = rem_try - trial;
      root_nxt = {root_r[ctl_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_try;
      root_nxt = {root_r[ctl_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_comb begin
    total_sum = {1'b0, total_r} + (ctl_pkg::TOTAL_W + 1)'(root_r);
    total_nxt = total_sum[ctl_pkg::TOTAL_W] ? '1 : total_sum[ctl_pkg::TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else if (cmd.start_tour) begin
      started_r <= 1'b1;
    end else if (cmd.emit) begin
      started_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_tour) begin
      first_r <= cur_r;
      prev_r  <= cur_r;
      total_r <= '0;
    end
    if (cmd.leg_ld) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (cmd.mul_x || cmd.mul_y) begin
      prod_r <= ctl_pkg::PROD_W'(mul_op) * ctl_pkg::PROD_W'(mul_op);
    end
    if (cmd.mul_y) begin
      sqx_r <= prod_r;
    end
    if (cmd.root_init) begin
      rad_r  <= ctl_pkg::RAD_W'({sumsq, {ctl_pkg::FRAC_SHIFT{1'b0}}});
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.root_step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
    if (cmd.acc) begin
      total_r <= total_nxt;
    end
    if (cmd.upd_prev) begin
      prev_r <= cur_r;
    end
    if (cmd.emit) begin
      tour_length_r <= total_r;
    end
  end

endmodule

`default_nettype wire

[sv/closed_tour_length.sv]
// ----------------------------------------------------------------------------
// closed_tour_length
// Load request: writes the city table. Visit request: the first city starts
// the tour, a later one adds a leg (table read, two squares on one multiplier,
// 25-step root). Last visit adds the closing leg, then the result registers.
// Synchronous active-low reset clears the tour; the city table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module closed_tour_length (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_action,
  input  wire logic [9:0]                  in_city_index,
  input  wire logic signed [15:0]          in_coord_x,
  input  wire logic signed [15:0]          in_coord_y,
  input  wire logic                        in_last_visit,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ctl_pkg::TOTAL_W-1:0]      out_tour_length
);

  ctl_pkg::cmd_t cmd;
  ctl_pkg::sts_t sts;
  logic          accept;

  assign accept = in_valid && !in_stall;

  ctl_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_last_visit (in_last_visit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sts           (sts)
  );

  ctl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_city_index   (in_city_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .cmd             (cmd),
    .sts             (sts),
    .out_tour_length (out_tour_length)
  );

  `CTL_ASSERT_NEXT(a_visit_busy, clk, rst_n, accept && in_action, in_stall)
  `CTL_ASSERT_NEXT(a_load_free, clk, rst_n, accept && !in_action, !in_stall)
  `CTL_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

`default_nettype wire
